/* rtl/core/ralu_pkg.sv */
// Shared types and constants for the rational ALU.
package ralu_pkg;

	localparam int WORD_BITS = 32;
	localparam int PROD_BITS = 64;
	localparam logic [PROD_BITS-1:0] RES_LIM = PROD_BITS'(1) << (WORD_BITS - 1);

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_EQ  = 3'd4;
	localparam logic [2:0] MODE_LT  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL_A,
		CMD_MUL_B,
		CMD_MUL_C,
		CMD_COMBINE,
		CMD_GCD,
		CMD_GCD_END,
		CMD_DIV,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic arith;
		logic zero;
		logic gcd_done;
		logic div_last;
	} sts_t;

endpackage

/* rtl/core/ralu_dp.sv */
// Datapath: shared multiplier, binary gcd, dual restoring divider, result registers.
module ralu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ralu_pkg::cmd_t     cmd,
	output ralu_pkg::sts_t     sts,
	input  logic [2:0]         mode,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic               compare_true,
	output logic [1:0]         status
);
	import ralu_pkg::*;

	logic [2:0]                mode_q;
	logic signed [31:0]        an_q, bn_q;
	logic [30:0]               ad_q, bd_q;
	logic signed [PROD_BITS-1:0] p1_q, p2_q, p3_q;
	logic [PROD_BITS-1:0]      nmag_q, dmag_q, x_q, y_q, g_q, r1_q, r2_q;
	logic                      neg_q;
	logic [5:0]                k_q, cnt_q;

	logic signed [32:0]        mx, my;
	logic signed [65:0]        prod;
	logic signed [PROD_BITS-1:0] num_c, den_c;
	logic [PROD_BITS-1:0]      r1_n, r2_n;
	logic                      b_zero, ovf;

	assign b_zero = (bn_q == '0);

	always_comb begin
		mx = {an_q[31], an_q};
		my = {2'b00, bd_q};
		case (cmd)
			CMD_MUL_A: begin
				mx = {an_q[31], an_q};
				my = (mode_q == MODE_MUL) ? {bn_q[31], bn_q} : {2'b00, bd_q};
			end
			CMD_MUL_B: begin
				mx = {bn_q[31], bn_q};
				my = {2'b00, ad_q};
			end
			CMD_MUL_C: begin
				mx = {2'b00, ad_q};
				my = {2'b00, bd_q};
			end
			default: ;
		endcase
	end
	assign prod = mx * my;

	always_comb begin
		case (mode_q)
			MODE_ADD: num_c = p1_q + p2_q;
			MODE_SUB: num_c = p1_q - p2_q;
			default:  num_c = p1_q;
		endcase
		den_c = (mode_q == MODE_DIV) ? p2_q : p3_q;
	end

	// one restoring step per lane, divisor is the gcd
	always_comb begin
		r1_n = {r1_q[PROD_BITS-2:0], nmag_q[PROD_BITS-1]};
		r2_n = {r2_q[PROD_BITS-2:0], dmag_q[PROD_BITS-1]};
	end

	assign ovf = (neg_q ? (nmag_q > RES_LIM) : (nmag_q >= RES_LIM)) || (dmag_q >= RES_LIM);

	assign sts.arith    = (mode_q inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV})
	                      && !(mode_q == MODE_DIV && b_zero);
	assign sts.zero     = (nmag_q == '0);
	assign sts.gcd_done = (x_q == '0) || (y_q == '0);
	assign sts.div_last = (cnt_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_num      <= '0;
			res_den      <= 31'd1;
			compare_true <= 1'b0;
			status       <= ST_OK;
		end else if (cmd == CMD_FINISH) begin
			res_num      <= '0;
			res_den      <= 31'd1;
			compare_true <= 1'b0;
			status       <= ST_OK;
			if (mode_q == MODE_DIV && b_zero) begin
				status <= ST_DIV0;
			end else if (sts.arith) begin
				if (!sts.zero) begin
					if (ovf) begin
						status <= ST_OVF;
					end else begin
						res_num <= neg_q ? -nmag_q[31:0] : nmag_q[31:0];
						res_den <= dmag_q[30:0];
					end
				end
			end else if (mode_q == MODE_EQ) begin
				compare_true <= (p1_q == p2_q);
			end else if (mode_q == MODE_LT) begin
				compare_true <= (p1_q < p2_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				mode_q <= mode;
				an_q   <= (a_den == '0) ? '0 : a_num;
				ad_q   <= (a_den == '0) ? 31'd1 : a_den;
				bn_q   <= (b_den == '0) ? '0 : b_num;
				bd_q   <= (b_den == '0) ? 31'd1 : b_den;
			end
			CMD_MUL_A: p1_q <= prod[PROD_BITS-1:0];
			CMD_MUL_B: p2_q <= prod[PROD_BITS-1:0];
			CMD_MUL_C: p3_q <= prod[PROD_BITS-1:0];
			CMD_COMBINE: begin
				neg_q  <= num_c[PROD_BITS-1] ^ den_c[PROD_BITS-1];
				nmag_q <= num_c[PROD_BITS-1] ? -num_c : num_c;
				dmag_q <= den_c[PROD_BITS-1] ? -den_c : den_c;
				x_q    <= num_c[PROD_BITS-1] ? -num_c : num_c;
				y_q    <= den_c[PROD_BITS-1] ? -den_c : den_c;
				k_q    <= '0;
			end
			CMD_GCD: begin
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 6'd1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			CMD_GCD_END: begin
				// one of x, y is zero here
				g_q   <= (x_q | y_q) << k_q;
				r1_q  <= '0;
				r2_q  <= '0;
				cnt_q <= '0;
			end
			CMD_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (r1_n >= g_q) begin
					r1_q   <= r1_n - g_q;
					nmag_q <= {nmag_q[PROD_BITS-2:0], 1'b1};
				end else begin
					r1_q   <= r1_n;
					nmag_q <= {nmag_q[PROD_BITS-2:0], 1'b0};
				end
				if (r2_n >= g_q) begin
					r2_q   <= r2_n - g_q;
					dmag_q <= {dmag_q[PROD_BITS-2:0], 1'b1};
				end else begin
					r2_q   <= r2_n;
					dmag_q <= {dmag_q[PROD_BITS-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/ralu_ctrl.sv */
// Controller state machine sequencing multiply, gcd, divide and finish.
module ralu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output ralu_pkg::cmd_t cmd,
	input  ralu_pkg::sts_t sts
);
	import ralu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_A, S_MUL_B, S_MUL_C, S_COMB, S_GCD, S_GEND, S_DIV, S_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		case (state_q)
			S_IDLE:  cmd = start ? CMD_LOAD : CMD_NONE;
			S_MUL_A: cmd = CMD_MUL_A;
			S_MUL_B: cmd = CMD_MUL_B;
			S_MUL_C: cmd = CMD_MUL_C;
			S_COMB:  cmd = CMD_COMBINE;
			S_GCD:   cmd = (!sts.arith || sts.zero) ? CMD_NONE :
			               (sts.gcd_done ? CMD_NONE : CMD_GCD);
			S_GEND:  cmd = CMD_GCD_END;
			S_DIV:   cmd = CMD_DIV;
			S_FIN:   cmd = CMD_FINISH;
			default: cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_MUL_A;
					busy    <= 1'b1;
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_MUL_C;
				S_MUL_C: state_q <= S_COMB;
				S_COMB:  state_q <= S_GCD;
				S_GCD: begin
					if (!sts.arith || sts.zero) state_q <= S_FIN;
					else if (sts.gcd_done)      state_q <= S_GEND;
				end
				S_GEND: state_q <= S_DIV;
				S_DIV:  if (sts.div_last) state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
					done    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item accepted but not busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> done) else $error("finish without strobe");

endmodule

/* rtl/core/rational_alu_with_reduction_top.sv */
// Rational ALU top level: add, subtract, multiply, divide, compare with gcd reduction.
// Compare, error and zero-numerator items go from S_GCD straight to S_FIN; other arithmetic items
// also run the binary gcd loop (S_GCD) and the divider (S_GEND, S_DIV) before S_FIN.
// Throughput: one item at a time; busy stays high from accept until done.
// The gcd loop and the 64-step divider (both lanes in parallel) set how long an arithmetic item takes.
// Reset: arst_n asynchronous active low, clears controller to idle and the result ports.
// Each result is shown one cycle with done high; the receiver cannot stall.
module rational_alu_with_reduction_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [2:0]         mode,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic               compare_true,
	output logic [1:0]         status
);
	import ralu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: accepts start when not busy, steps the datapath
	ralu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// operand capture, products, reduction and result registers
	ralu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.a_num        (a_num),
		.a_den        (a_den),
		.b_num        (b_num),
		.b_den        (b_den),
		.res_num      (res_num),
		.res_den      (res_den),
		.compare_true (compare_true),
		.status       (status)
	);

endmodule

/* sim/tb_rational_alu_with_reduction_top.sv */
// Testbench for the rational ALU: random and corner fractions checked against a predictor.
`timescale 1ns / 1ps

module tb_rational_alu_with_reduction_top;
	import ralu_pkg::*;

	// One operation item as driven on the command ports.
	typedef struct {
		logic [2:0]         mode;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} op_item_t;

	// One reduced fraction with flags, as shown with done.
	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic               cmp;
		logic [1:0]         st;
	} frac_res_t;

	localparam int WATCHDOG_CYCLES = 20000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	logic [2:0]         mode;
	logic signed [31:0] a_num;
	logic [30:0]        a_den;
	logic signed [31:0] b_num;
	logic [30:0]        b_den;
	logic signed [31:0] res_num;
	logic [30:0]        res_den;
	logic               compare_true;
	logic [1:0]         status;

	op_item_t  pending_ops[$];
	frac_res_t expected_fracs[$];
	int        send_idle_pct;
	bit        hold_for_drain;
	int        n_errors;
	int        n_checked;
	int        n_sent;
	int        quiet_cycles;

	rational_alu_with_reduction_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.done         (done),
		.mode         (mode),
		.a_num        (a_num),
		.a_den        (a_den),
		.b_num        (b_num),
		.b_den        (b_den),
		.res_num      (res_num),
		.res_den      (res_den),
		.compare_true (compare_true),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Binary-free Euclid on magnitudes; both arguments nonzero or y zero.
	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Exact rational result of one item, reduced to lowest terms.
	function automatic frac_res_t reduce_rational(op_item_t it);
		frac_res_t         r;
		logic signed [63:0] an, ad, bn, bd, num, den, lim;
		logic [63:0]       g, mag;
		bit                arith;
		an = 64'(it.a_num);
		ad = {33'd0, it.a_den};
		bn = 64'(it.b_num);
		bd = {33'd0, it.b_den};
		num = 0;
		den = 1;
		arith = 0;
		r.cmp = 1'b0;
		r.st = ST_OK;
		// A zero denominator turns the operand into 0/1.
		if (ad == 0) begin
			an = 0;
			ad = 1;
		end
		if (bd == 0) begin
			bn = 0;
			bd = 1;
		end
		case (it.mode)
			MODE_ADD: begin
				num = an * bd + bn * ad; den = ad * bd; arith = 1;
			end
			MODE_SUB: begin
				num = an * bd - bn * ad; den = ad * bd; arith = 1;
			end
			MODE_MUL: begin
				num = an * bn; den = ad * bd; arith = 1;
			end
			MODE_DIV: begin
				if (bn == 0) r.st = ST_DIV0;
				else begin
					num = an * bd; den = ad * bn; arith = 1;
				end
			end
			MODE_EQ: r.cmp = (an * bd == bn * ad);
			MODE_LT: r.cmp = (an * bd < bn * ad);
			default: ;
		endcase
		if (arith) begin
			// Sign goes to the numerator.
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			if (num == 0) den = 1;
			else begin
				mag = (num < 0) ? -num : num;
				g = gcd64(mag, den);
				num = num / $signed(g);
				den = den / $signed(g);
			end
			lim = 64'sd1 <<< (WORD_BITS - 1);
			if (num < -lim || num >= lim || den >= lim) begin
				num = 0;
				den = 1;
				r.st = ST_OVF;
			end
		end else begin
			num = 0;
			den = 1;
		end
		r.num = num[31:0];
		r.den = den[30:0];
		return r;
	endfunction

	function automatic logic [31:0] rnd_num();
		case ($urandom_range(0, 5))
			0: return 32'($signed($urandom_range(0, 40)) - 20);
			1: return 32'h8000_0000 + $urandom_range(0, 2);
			2: return 32'h7fff_ffff - $urandom_range(0, 2);
			3: return 32'($urandom_range(0, 65535)) - 32'd32768;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rnd_den();
		case ($urandom_range(0, 5))
			0: return 31'd1;
			1: return 31'($urandom_range(0, 12));
			2: return 31'h7fff_ffff - 31'($urandom_range(0, 2));
			3: return 31'($urandom_range(1, 65535));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic queue_op(logic [2:0] m, logic [31:0] an, logic [30:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		op_item_t it;
		it.mode = m;
		it.a_num = an;
		it.a_den = ad;
		it.b_num = bn;
		it.b_den = bd;
		pending_ops.push_back(it);
	endtask

	// Driver: offers the head of the queue; an item leaves at the edge it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_fracs.push_back(reduce_rational(pending_ops.pop_front()));
				n_sent <= n_sent + 1;
			end
			// Decide for the next cycle; start may stay high across items.
			if ((start && !busy ? pending_ops.size() > 0 : pending_ops.size() > 0 && !start)
					|| (start && busy)) begin
				if (start && busy) start <= 1'b1;
				else if (hold_for_drain || $urandom_range(0, 99) < send_idle_pct)
					start <= 1'b0;
				else begin
					start <= 1'b1;
					mode  <= pending_ops[0].mode;
					a_num <= pending_ops[0].a_num;
					a_den <= pending_ops[0].a_den;
					b_num <= pending_ops[0].b_num;
					b_den <= pending_ops[0].b_den;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each done pulse is compared with the oldest prediction.
	always @(posedge clk) begin
		frac_res_t e;
		if (arst_n && done) begin
			if (expected_fracs.size() == 0) begin
				$display("%0t: result with nothing expected: %0d/%0d cmp %0b st %0d",
					$time, res_num, res_den, compare_true, status);
				n_errors++;
			end else begin
				e = expected_fracs.pop_front();
				n_checked++;
				if (res_num !== e.num) begin
					$display("%0t: res_num expected %0d actual %0d", $time, e.num, res_num);
					n_errors++;
				end
				if (res_den !== e.den) begin
					$display("%0t: res_den expected %0d actual %0d", $time, e.den, res_den);
					n_errors++;
				end
				if (compare_true !== e.cmp) begin
					$display("%0t: compare_true expected %0b actual %0b",
						$time, e.cmp, compare_true);
					n_errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles with no accept on either side.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		start = 1'b0;
		mode = MODE_ADD;
		a_num = 0;
		a_den = 31'd1;
		b_num = 0;
		b_den = 31'd1;
		send_idle_pct = 29;
		hold_for_drain = 0;
		n_errors = 0;
		n_checked = 0;
		n_sent = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every mode, field extremes, zero denominators, divide by zero,
		// overflow, unreduced operands, unused modes.
		queue_op(MODE_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
		queue_op(MODE_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
		queue_op(MODE_MUL, -32'sd2, 31'd3, 32'sd3, 31'd4);
		queue_op(MODE_DIV, 32'sd1, 31'd2, -32'sd3, 31'd4);
		queue_op(MODE_DIV, 32'sd5, 31'd7, 32'sd0, 31'd9);
		queue_op(MODE_DIV, 32'sd5, 31'd7, 32'sd3, 31'd0);
		queue_op(MODE_EQ, 32'sd2, 31'd4, 32'sd1, 31'd2);
		queue_op(MODE_EQ, 32'sd1, 31'd3, 32'sd1, 31'd2);
		queue_op(MODE_LT, -32'sd1, 31'd2, 32'sd1, 31'd3);
		queue_op(MODE_LT, 32'sd1, 31'd2, 32'sd1, 31'd3);
		queue_op(MODE_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
		queue_op(MODE_SUB, 32'h8000_0000, 31'd1, 32'sd1, 31'd1);
		queue_op(MODE_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
		queue_op(MODE_MUL, 32'h8000_0000, 31'd1, -32'sd1, 31'd1);
		queue_op(MODE_DIV, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
		queue_op(MODE_DIV, 32'sd1, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1);
		queue_op(MODE_ADD, 32'sd3, 31'd0, 32'sd4, 31'd0);
		queue_op(MODE_ADD, 32'sd6, 31'd8, 32'sd10, 31'd12);
		queue_op(MODE_LT, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
		queue_op(3'd6, 32'sd1, 31'd1, 32'sd1, 31'd1);
		queue_op(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
		queue_op(MODE_ADD, 32'sd0, 31'd5, 32'sd0, 31'd7);

		// Random part: about 1350 items, mostly legal modes.
		for (int i = 0; i < 1350; i++) begin
			queue_op((($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5))), rnd_num(), rnd_den(), rnd_num(), rnd_den());
			if (i == 450) queue_op(MODE_EQ, 32'sd1, 31'd1, 32'sd1, 31'd1);
		end

		// Phase switches: sender idling, then none; one pause for a full drain.
		wait (n_sent >= 470);
		@(posedge clk);
		hold_for_drain <= 1;
		wait (expected_fracs.size() == 0 && !busy);
		@(posedge clk);
		hold_for_drain <= 0;
		send_idle_pct <= 61;
		wait (n_sent >= 920);
		@(posedge clk);
		send_idle_pct <= 0;

		wait (pending_ops.size() == 0 && !start);
		wait (expected_fracs.size() == 0);
		repeat (300) @(posedge clk);

		$display("Ran %0d items through all six modes and the unused codes, %0d results checked,",
			n_sent, n_checked);
		$display("including overflow, divide by zero and zero denominators.");
		if (n_errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
